// ===== hdl/sph_pkg.sv =====
// ----------------------------------------------------------------------------
// sph_pkg
// Shared types and constants for the sphenic number classifier.
// ----------------------------------------------------------------------------
package sph_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 16;
   localparam int NEEDED_PRIMES       = 3;
   localparam int FIRST_DIVISOR       = 2;
   localparam int PRIME_COUNT_WIDTH   = 3;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_CHECK  = 6'b000010,
      ST_DIV1   = 6'b000100,
      ST_TEST1  = 6'b001000,
      ST_DIV2   = 6'b010000,
      ST_TEST2  = 6'b100000
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic load;          // take a new number, restart at the first divisor
      logic div_start;     // launch a division
      logic div_src_quot;  // dividend is the last quotient instead of the remainder
      logic take_quot;     // remainder <= quotient, count one more prime
      logic next_div;      // advance to the next trial divisor
      logic report;        // register the result
      logic report_no;     // result is a forced no
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic sq_gt_rem;     // divisor squared exceeds the remainder
      logic div_done;      // division finished
      logic div_rem_zero;  // divisor divides the dividend
      logic primes_full;   // three primes already counted
   } status_type;

endpackage

// ===== hdl/sph_div.sv =====
// ----------------------------------------------------------------------------
// sph_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sph_div
   import sph_pkg::*;
#(
   parameter int WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient,
   output logic             rem_zero
);

   localparam int CNT_WIDTH = $clog2(WIDTH + 1);

   logic [CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [WIDTH-1:0]     q_ff, q_in;
   logic [WIDTH-1:0]     r_ff, r_in;
   logic [WIDTH:0]       trial;
   logic [WIDTH:0]       diff;

   assign trial = {r_ff, q_ff[WIDTH-1]};
   assign diff  = trial - {1'b0, divisor};

   always_comb begin
      cnt_in = cnt_ff;
      q_in   = q_ff;
      r_in   = r_ff;
      if (start) begin
         cnt_in = CNT_WIDTH'(WIDTH);
         q_in   = dividend;
         r_in   = '0;
      end else if (cnt_ff != '0) begin
         cnt_in = cnt_ff - 1'b1;
         if (!diff[WIDTH]) begin
            r_in = diff[WIDTH-1:0];
            q_in = {q_ff[WIDTH-2:0], 1'b1};
         end else begin
            r_in = trial[WIDTH-1:0];
            q_in = {q_ff[WIDTH-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
   end

   assign done     = (cnt_ff == '0);
   assign quotient = q_ff;
   assign rem_zero = (r_ff == '0);

endmodule

// ===== hdl/sph_datapath.sv =====
// ----------------------------------------------------------------------------
// sph_datapath
// Remainder, trial divisor, running square, prime count and result register.
// ----------------------------------------------------------------------------
module sph_datapath
   import sph_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [VALUE_WIDTH-1:0] number,
   input  cmd_type                cmd,
   output status_type             status,
   output logic                   is_sphenic
);

   localparam int SQ_WIDTH = VALUE_WIDTH + 2;

   logic [VALUE_WIDTH-1:0]       rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0]       d_ff, d_in;
   logic [SQ_WIDTH-1:0]          sq_ff, sq_in;
   logic [PRIME_COUNT_WIDTH-1:0] primes_ff, primes_in;
   logic                         result_ff, result_in;
   logic [VALUE_WIDTH-1:0]       dividend;
   logic [VALUE_WIDTH-1:0]       quot;
   logic                         div_done;
   logic                         div_rem_zero;
   logic [PRIME_COUNT_WIDTH-1:0] final_count;

   assign dividend = cmd.div_src_quot ? quot : rem_ff;

   sph_div #(
      .WIDTH (VALUE_WIDTH)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (d_ff),
      .done     (div_done),
      .quotient (quot),
      .rem_zero (div_rem_zero)
   );

   // a leftover remainder above one is the last prime
   assign final_count = primes_ff + PRIME_COUNT_WIDTH'(rem_ff > VALUE_WIDTH'(1));

   always_comb begin
      rem_in    = rem_ff;
      d_in      = d_ff;
      sq_in     = sq_ff;
      primes_in = primes_ff;
      result_in = result_ff;
      if (cmd.load) begin
         rem_in    = number;
         d_in      = VALUE_WIDTH'(FIRST_DIVISOR);
         sq_in     = SQ_WIDTH'(FIRST_DIVISOR * FIRST_DIVISOR);
         primes_in = '0;
      end
      if (cmd.take_quot) begin
         rem_in    = quot;
         primes_in = primes_ff + 1'b1;
      end
      if (cmd.next_div) begin
         d_in  = d_ff + 1'b1;
         // (d+1)^2 = d^2 + 2d + 1
         sq_in = sq_ff + SQ_WIDTH'({d_ff, 1'b1});
      end
      if (cmd.report) begin
         result_in = !cmd.report_no && (final_count == PRIME_COUNT_WIDTH'(NEEDED_PRIMES));
      end
   end

   always_ff @(posedge clock) begin
      rem_ff    <= rem_in;
      d_ff      <= d_in;
      sq_ff     <= sq_in;
      primes_ff <= primes_in;
      result_ff <= result_in;
   end

   assign status.sq_gt_rem    = (sq_ff > SQ_WIDTH'(rem_ff));
   assign status.div_done     = div_done;
   assign status.div_rem_zero = div_rem_zero;
   assign status.primes_full  = (primes_ff == PRIME_COUNT_WIDTH'(NEEDED_PRIMES));
   assign is_sphenic          = result_ff;

endmodule

// ===== hdl/sph_ctrl.sv =====
// ----------------------------------------------------------------------------
// sph_ctrl
// Sequencer for trial division: check bound, divide, test, divide again.
// ----------------------------------------------------------------------------
module sph_ctrl
   import sph_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   input  status_type status,
   output cmd_type    cmd,
   output logic       busy,
   output logic       strobe
);

   state_type state_ff, state_in;
   logic      strobe_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (status.sq_gt_rem) begin
               cmd.report = 1'b1;
               state_in   = ST_IDLE;
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV1;
            end
         end
         ST_DIV1: begin
            if (status.div_done) begin
               state_in = ST_TEST1;
            end
         end
         ST_TEST1: begin
            priority if (!status.div_rem_zero) begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end else if (status.primes_full) begin
               // a fourth prime: drop out with no
               cmd.report    = 1'b1;
               cmd.report_no = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               // keep the quotient and test it for a repeated factor
               cmd.take_quot    = 1'b1;
               cmd.div_start    = 1'b1;
               cmd.div_src_quot = 1'b1;
               state_in         = ST_DIV2;
            end
         end
         ST_DIV2: begin
            if (status.div_done) begin
               state_in = ST_TEST2;
            end
         end
         ST_TEST2: begin
            if (status.div_rem_zero) begin
               cmd.report    = 1'b1;
               cmd.report_no = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               cmd.next_div = 1'b1;
               state_in     = ST_CHECK;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= cmd.report;
      end
   end

   assign busy   = (state_ff != ST_IDLE);
   assign strobe = strobe_ff;

endmodule

// ===== hdl/sphenic_number_test.sv =====
// ----------------------------------------------------------------------------
// sphenic_number_test
// Reports whether a number is the product of three distinct primes.
// ----------------------------------------------------------------------------
// Input: drive req_number and raise start while busy is low; that cycle
// transfers the number and busy rises on the next cycle. busy stays high
// while the number is worked on, and no new number is taken meanwhile.
// Output: rsp_is_sphenic is valid for the single cycle in which rsp_strobe
// is high; the receiver cannot stall and must take it then. The strobe
// comes in the first cycle with busy low again, and a new start may be
// given in that same cycle.
// Operation: trial division by 2, 3, 4 and on while the divisor squared
// does not exceed the remainder. Each trial is a bound check, a division
// on the shared restoring divider at one quotient bit per cycle, and a
// test, plus a second division when the divisor divides and the quotient
// is checked for a repeated factor. A new number is taken only after the
// result of the last one is given.
// Reset: synchronous, active high; returns the sequencer to idle and
// clears the strobe. No other state survives from one number to the next.
// ----------------------------------------------------------------------------
module sphenic_number_test
   import sph_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_number,
   output logic                   rsp_strobe,
   output logic                   rsp_is_sphenic
);

   cmd_type    cmd;
   status_type status;

   sph_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .strobe (rsp_strobe)
   );

   sph_datapath #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .number     (req_number),
      .cmd        (cmd),
      .status     (status),
      .is_sphenic (rsp_is_sphenic)
   );

   // a result only follows a number in progress
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy))
   else $error("result strobe without a number in progress");

   // the sequencer is back at idle when the result shows
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
   else $error("result strobe while still busy");

   // a transfer always starts work
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
   else $error("number transferred but busy did not rise");

   // a result is a single-cycle pulse
   assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
   else $error("result strobe longer than one cycle");

endmodule

// ===== bench/sphenic_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sphenic_checker
// Watches the number and verdict channels of the sphenic classifier. Every
// number transfer gets its verdict worked out by trial division, and each
// verdict strobe is compared with the oldest one still owed.
// ----------------------------------------------------------------------------
module sphenic_checker
   import sph_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  logic [VALUE_WIDTH-1:0] req_number,
   input  logic                   rsp_strobe,
   input  logic                   rsp_is_sphenic,
   output int                     mismatches,
   output int                     outstanding
);

   typedef struct {
      logic [VALUE_WIDTH-1:0] number;
      logic                   is_sphenic;
   } verdict_type;

   verdict_type owed_verdicts[$];
   int          error_count = 0;

   // Divide out each trial divisor; a second division by it means a square.
   function automatic logic sphenic_verdict(input logic [VALUE_WIDTH-1:0] number);
      longint unsigned remainder;
      longint unsigned divisor;
      int              prime_count;
      remainder   = number;
      divisor     = FIRST_DIVISOR;
      prime_count = 0;
      if (remainder < 2) return 1'b0;
      while (divisor * divisor <= remainder) begin
         if (remainder % divisor == 0) begin
            remainder = remainder / divisor;
            if (remainder % divisor == 0) return 1'b0;
            prime_count++;
            if (prime_count > NEEDED_PRIMES) return 1'b0;
         end
         divisor++;
      end
      if (remainder > 1) prime_count++;
      return (prime_count == NEEDED_PRIMES);
   endfunction

   always @(posedge clock) begin
      verdict_type owed;
      verdict_type fresh;
      if (!reset) begin
         if (rsp_strobe) begin
            if (owed_verdicts.size() == 0) begin
               $error("is_sphenic: no verdict owed, got %0b", rsp_is_sphenic);
               error_count++;
            end else begin
               owed = owed_verdicts.pop_front();
               if (rsp_is_sphenic !== owed.is_sphenic) begin
                  $error("is_sphenic: number %0d expected %0b actual %0b",
                         owed.number, owed.is_sphenic, rsp_is_sphenic);
                  error_count++;
               end
            end
         end
         if (start && !busy) begin
            fresh.number     = req_number;
            fresh.is_sphenic = sphenic_verdict(req_number);
            owed_verdicts.push_back(fresh);
         end
      end
      mismatches  <= error_count;
      outstanding <= owed_verdicts.size();
   end

endmodule

// ===== bench/tb_sphenic_number_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sphenic_number_test
// Drives numbers into the sphenic classifier: a directed set of edge values,
// then random products of three distinct primes mixed with near misses
// (squares, two or four primes, single primes) and plain random values,
// under several sender idling phases. The checker scores every verdict.
// ----------------------------------------------------------------------------
module tb_sphenic_number_test;
   import sph_pkg::*;

   localparam int VALUE_WIDTH = VALUE_WIDTH_DEFAULT;
   localparam int MAX_NUMBER  = (1 << VALUE_WIDTH) - 1;
   localparam int PHASE_ITEMS = 30;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   logic [VALUE_WIDTH-1:0] req_number;
   logic                   rsp_strobe;
   logic                   rsp_is_sphenic;
   int                     mismatches;
   int                     outstanding;

   bit                     composite [0:MAX_NUMBER];

   sphenic_number_test #(.VALUE_WIDTH(VALUE_WIDTH)) dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_strobe     (rsp_strobe),
      .rsp_is_sphenic (rsp_is_sphenic)
   );

   sphenic_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_checker (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_number     (req_number),
      .rsp_strobe     (rsp_strobe),
      .rsp_is_sphenic (rsp_is_sphenic),
      .mismatches     (mismatches),
      .outstanding    (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Random prime in [lo, hi], or 0 when the range holds none.
   function automatic int pick_prime(input int lo, input int hi);
      int first;
      if (lo < 2) lo = 2;
      if (hi > MAX_NUMBER) hi = MAX_NUMBER;
      if (lo > hi) return 0;
      first = $urandom_range(hi, lo);
      for (int v = first; v <= hi; v++) if (!composite[v]) return v;
      for (int v = lo; v < first; v++) if (!composite[v]) return v;
      return 0;
   endfunction

   function automatic int random_number();
      int kind;
      int p, q, r, s;
      kind = $urandom_range(99, 0);
      if (kind < 45) begin
         // three distinct primes in rising order, product in range
         do begin
            p = pick_prime(2, 40);
            q = pick_prime(p + 1, $rtoi($sqrt(real'(MAX_NUMBER / p))));
            r = (q == 0) ? 0 : pick_prime(q + 1, MAX_NUMBER / (p * q));
         end while (r == 0);
         return p * q * r;
      end else if (kind < 60) begin
         // repeated factor
         p = pick_prime(2, 255);
         q = pick_prime(2, MAX_NUMBER / (p * p));
         return (q == 0) ? p * p : p * p * q;
      end else if (kind < 72) begin
         do begin
            p = pick_prime(2, 7);
            q = pick_prime(p + 1, 23);
            r = pick_prime(q + 1, 60);
            s = (r == 0) ? 0 : pick_prime(r + 1, MAX_NUMBER / (p * q * r));
         end while (s == 0);
         return p * q * r * s;
      end else if (kind < 80) begin
         p = pick_prime(2, 255);
         q = pick_prime(p + 1, MAX_NUMBER / p);
         return (q == 0) ? p : p * q;
      end else if (kind < 85) begin
         return pick_prime(2, MAX_NUMBER);
      end else if (kind < 90) begin
         return $urandom_range(15, 0);
      end
      return $urandom_range(MAX_NUMBER, 0);
   endfunction

   // Hold the number until a transfer happens; idle before it at random.
   task automatic send_number(input int number, input int idle_pct);
      while ($urandom_range(99, 0) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start      <= 1'b1;
      req_number <= number[VALUE_WIDTH-1:0];
      do @(posedge clock); while (busy);
   endtask

   initial begin
      int directed[$];
      int idle_pct[4];
      int big_prime;
      reset      = 1'b1;
      start      = 1'b0;
      req_number = '0;
      idle_pct   = '{0, 74, 0, 26};

      composite[0] = 1'b1;
      composite[1] = 1'b1;
      for (int i = 2; i * i <= MAX_NUMBER; i++)
         if (!composite[i])
            for (int j = i * i; j <= MAX_NUMBER; j += i) composite[j] = 1'b1;

      big_prime = MAX_NUMBER / 6;
      while (composite[big_prime]) big_prime--;

      // edge values, squares and cubes, four-prime products, bit patterns
      directed = '{0, 1, 2, 3, 4, 8, 12, 30, 42, 60, 210, 255, 1001, 21845, 43690,
                   30030, 32768, 63001, 65521, 65534, 65535, 6 * big_prime,
                   2 * 32749};

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_number(directed[i], 0);
      foreach (idle_pct[ph])
         repeat (PHASE_ITEMS) send_number(random_number(), idle_pct[ph]);
      start <= 1'b0;

      // let the count of owed verdicts pick up the last transfer first
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
